// ===== hw/rtl/bba_pkg.sv =====
// shared types and constants for the block bitmap allocator
`default_nettype none

package bba_pkg;

    // bitmap geometry
    localparam int NUM_BLOCKS    = 4096;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_DEPTH     = NUM_BLOCKS / MAP_WORD_BITS;
    localparam int ROW_W         = $clog2(MAP_DEPTH);
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);

    // field widths
    localparam int BLK_W = 12;
    localparam int CNT_W = 13;
    localparam int ST_W  = 2;

    localparam logic [MAP_WORD_BITS-1:0] WORD_ONE = MAP_WORD_BITS'(1);

    // request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE       = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_NOT_IN_USE = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FCHK,
        S_RESP
    } state_t;

    // answer of the word search unit
    typedef struct packed {
        logic                     found;
        logic [BIT_W-1:0]         bit_idx;
        logic [MAP_WORD_BITS-1:0] set_word;
    } find_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_find.sv =====
// search unit: lowest free in-range bit of one bitmap word
`default_nettype none

module bba_find (
    input  wire logic [bba_pkg::MAP_WORD_BITS-1:0] word,
    input  wire logic [bba_pkg::ROW_W-1:0]         row,
    input  wire logic [bba_pkg::ROW_W-1:0]         last_row,
    input  wire logic [bba_pkg::BIT_W-1:0]         last_bit,
    output bba_pkg::find_t                         result
);

    import bba_pkg::*;

    logic [MAP_WORD_BITS-1:0] busy;
    logic [MAP_WORD_BITS-1:0] high_mask;

    // bits above the last block of the last row count as busy
    assign high_mask = {MAP_WORD_BITS{1'b1}} >> (BIT_W'(MAP_WORD_BITS - 1) - last_bit);

    always_comb
    begin
        busy = word;
        if (row == '0)
        begin
            busy[0] = 1'b1;
        end
        if (row == last_row)
        begin
            busy = busy | ~high_mask;
        end
    end

    // priority pick of the lowest zero bit
    always_comb
    begin
        result.found   = 1'b0;
        result.bit_idx = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (!busy[i])
            begin
                result.found   = 1'b1;
                result.bit_idx = BIT_W'(i);
            end
        end
        result.set_word = word | (WORD_ONE << result.bit_idx);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/block_bitmap_allocator.sv =====
// top level of the first-fit block bitmap allocator
`default_nettype none

// First-fit disk block allocator. The used/free bitmap (4096 blocks) sits in a
// 128 x 32 ram; a per-row valid bit, cleared by reset, makes every row read as
// all free until it is first written, so the block is ready right after reset.
// An allocate request scans one bitmap word per cycle through the single read
// port, from row 0 up to the row holding block count minus one; with a count
// below two it answers no-free without a scan. A free request reads the word
// of its block, checks the bit and clears it if set. The result sits in an
// output register; a new request is taken while that result waits, but the
// next result is held back until the previous beat has been taken.
module block_bitmap_allocator (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration
    input  wire logic                     cfg_wr_en,
    input  wire logic [bba_pkg::CNT_W-1:0] cfg_wr_data,
    // request channel
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     operation,
    input  wire logic [bba_pkg::BLK_W-1:0] block_number,
    // result channel
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [bba_pkg::ST_W-1:0]      status,
    output logic [bba_pkg::BLK_W-1:0]     granted_block,
    output logic [bba_pkg::BLK_W-1:0]     free_remaining
);

    import bba_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [BLK_W-1:0]         bno_reg, bno_next;
    status_t                  res_status_reg, res_status_next;
    logic [BLK_W-1:0]         res_grant_reg, res_grant_next;
    logic [MAP_DEPTH-1:0]     row_valid_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [ST_W-1:0]          out_status_reg, out_status_next;
    logic [BLK_W-1:0]         out_grant_reg, out_grant_next;
    logic [BLK_W-1:0]         out_free_reg, out_free_next;

    logic                     ram_we;
    logic [ROW_W-1:0]         ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [MAP_WORD_BITS-1:0] ram_rdata;
    logic [MAP_WORD_BITS-1:0] map_word;

    logic [CNT_W-1:0]         n_eff;
    logic [CNT_W-1:0]         n_m1;
    logic [BLK_W-1:0]         free_left;
    logic                     free_bit;
    find_t                    find;

    // effective count and its last block
    assign n_eff = (count_reg > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : count_reg;
    assign n_m1  = n_eff - CNT_W'(1);

    // free blocks left, saturated at zero
    always_comb
    begin
        if (n_eff == '0 || n_m1 <= used_reg)
        begin
            free_left = '0;
        end
        else
        begin
            free_left = BLK_W'(n_m1 - used_reg);
        end
    end

    // bitmap storage
    bba_ram #(
        .WIDTH(MAP_WORD_BITS),
        .DEPTH(MAP_DEPTH)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(row_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // rows never written read as all free
    assign map_word = row_valid_reg[row_reg] ? ram_rdata : '0;
    assign free_bit = map_word[bno_reg[BIT_W-1:0]];

    // word search
    bba_find u_find (
        .word    (map_word),
        .row     (row_reg),
        .last_row(n_m1[BLK_W-1:BIT_W]),
        .last_bit(n_m1[BIT_W-1:0]),
        .result  (find)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        row_next        = row_reg;
        bno_next        = bno_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        out_free_next   = out_free_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_wdata       = find.set_word;
        ram_raddr       = row_reg + ROW_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                ram_raddr = (operation == OP_FREE) ? block_number[BLK_W-1:BIT_W] : '0;
                if (in_valid)
                begin
                    row_next       = ram_raddr;
                    bno_next       = block_number;
                    res_grant_next = '0;
                    if (operation == OP_FREE)
                    begin
                        state_next = S_FCHK;
                    end
                    else if (n_eff < CNT_W'(2))
                    begin
                        res_status_next = ST_NO_FREE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (find.found)
                begin
                    ram_we          = 1'b1;
                    used_next       = used_reg + CNT_W'(1);
                    res_grant_next  = {row_reg, find.bit_idx};
                    res_status_next = ST_DONE;
                    state_next      = S_RESP;
                end
                else if (row_reg == n_m1[BLK_W-1:BIT_W])
                begin
                    res_status_next = ST_NO_FREE;
                    state_next      = S_RESP;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            S_FCHK:
            begin
                ram_wdata = map_word & ~(WORD_ONE << bno_reg[BIT_W-1:0]);
                if ({1'b0, bno_reg} < n_eff && free_bit)
                begin
                    ram_we          = 1'b1;
                    used_next       = (used_reg != '0) ? used_reg - CNT_W'(1) : used_reg;
                    res_status_next = ST_DONE;
                end
                else
                begin
                    res_status_next = ST_NOT_IN_USE;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_grant_next  = res_grant_reg;
                    out_free_next   = free_left;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(NUM_BLOCKS);
            used_reg      <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (ram_we)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        bno_reg        <= bno_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
        out_free_reg   <= out_free_next;
    end

    // result beat
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_block  = out_grant_reg;
    assign free_remaining = out_free_reg;

`ifndef SYNTHESIS
    // used count never exceeds the map size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(NUM_BLOCKS))
        else $error("blocks in use count out of range");

    // a taken request drops in_ready in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a bitmap update is always followed by the result stage
    a_write_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> state_reg == S_RESP)
        else $error("bitmap write outside scan or free check");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_block_bitmap_allocator.sv =====
// testbench for the first-fit block bitmap allocator
`timescale 1ns / 100ps

module tb_block_bitmap_allocator;

    import bba_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 8;
    localparam int SHOW_MAX    = 10;

    // one expected answer of the allocator
    typedef struct packed {
        status_t          st;
        logic [BLK_W-1:0] grant;
        logic [BLK_W-1:0] left;
    } alloc_answer_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data   = '0;
    logic             in_valid      = 1'b0;
    logic             in_ready;
    logic             operation     = OP_ALLOC;
    logic [BLK_W-1:0] block_number  = '0;
    logic             out_valid;
    logic             out_ready     = 1'b0;
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] granted_block;
    logic [BLK_W-1:0] free_remaining;

    // shadow copy of the allocator state
    logic [NUM_BLOCKS-1:0] shadow_map   = '0;
    int                    shadow_used  = 0;
    logic [CNT_W-1:0]      shadow_count = CNT_W'(NUM_BLOCKS);

    alloc_answer_t    answers_due[$];
    logic [BLK_W-1:0] held_blocks[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycles         = 0;
    int mismatches     = 0;
    int beats_sent     = 0;
    int beats_checked  = 0;
    int count_writes   = 0;
    int no_free_seen   = 0;
    int not_in_use_seen = 0;

    block_bitmap_allocator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .block_number   (block_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_block  (granted_block),
        .free_remaining (free_remaining)
    );

    always #CLK_HALF clk = ~clk;

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding", cycles,
                     answers_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic int usable_blocks();
        return (shadow_count > CNT_W'(NUM_BLOCKS)) ? NUM_BLOCKS : int'(shadow_count);
    endfunction

    // first-fit search and free on the shadow bitmap
    function automatic alloc_answer_t grant_or_release(input logic op,
                                                       input logic [BLK_W-1:0] bno);
        alloc_answer_t ans;
        int            lim;
        int            i;
        logic          found;
        lim       = usable_blocks();
        ans.st    = ST_NO_FREE;
        ans.grant = '0;
        found     = 1'b0;
        if (op == OP_ALLOC)
        begin
            for (i = 1; i < lim && !found; i++)
            begin
                if (!shadow_map[i])
                begin
                    shadow_map[i] = 1'b1;
                    shadow_used++;
                    ans.grant = BLK_W'(i);
                    ans.st    = ST_DONE;
                    found     = 1'b1;
                end
            end
        end
        else if (int'(bno) < lim && shadow_map[bno])
        begin
            shadow_map[bno] = 1'b0;
            if (shadow_used > 0)
                shadow_used--;
            ans.st = ST_DONE;
        end
        else
        begin
            ans.st = ST_NOT_IN_USE;
        end
        if (lim < 1 || lim - 1 <= shadow_used)
            ans.left = '0;
        else
            ans.left = BLK_W'(lim - 1 - shadow_used);
        return ans;
    endfunction

    // compare each result beat with the oldest answer due
    always @(posedge clk)
    begin : check_results
        alloc_answer_t exp_ans;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result beat: status %0d grant %0d left %0d",
                             status, granted_block, free_remaining);
            end
            else
            begin
                exp_ans = answers_due.pop_front();
                if (status !== exp_ans.st || granted_block !== exp_ans.grant ||
                    free_remaining !== exp_ans.left)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch at beat %0d: exp st %0d grant %0d left %0d, got st %0d grant %0d left %0d",
                                 beats_checked, exp_ans.st, exp_ans.grant, exp_ans.left,
                                 status, granted_block, free_remaining);
                end
            end
        end
    end

    // send one request beat, with a random gap ahead of it
    task automatic send_req(input logic op, input logic [BLK_W-1:0] bno);
        alloc_answer_t ans;
        int            k;
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        block_number <= bno;
        do
            @(posedge clk);
        while (!in_ready);
        // beat taken at this edge
        beats_sent++;
        ans = grant_or_release(op, bno);
        answers_due.push_back(ans);
        if (ans.st == ST_NO_FREE)
            no_free_seen++;
        if (ans.st == ST_NOT_IN_USE)
            not_in_use_seen++;
        if (op == OP_ALLOC && ans.st == ST_DONE)
            held_blocks.push_back(ans.grant);
        if (op == OP_FREE && ans.st == ST_DONE)
        begin
            for (k = held_blocks.size() - 1; k >= 0; k--)
                if (held_blocks[k] == bno)
                    held_blocks.delete(k);
        end
    endtask

    // stop sending and wait for every answer to come back
    task automatic drain();
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        shadow_count = value;
        count_writes++;
        cfg_wr_en <= 1'b0;
    endtask

    // random mix of allocates and frees under one count and idling pattern
    task automatic run_mix(input int n_items, input logic [CNT_W-1:0] count,
                           input int alloc_pct, input int src_pct, input int snk_pct);
        int               n;
        int               pick;
        logic [BLK_W-1:0] bno;
        drain();
        write_count(count);
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        for (n = 0; n < n_items; n++)
        begin
            // let the block run dry once in the middle
            if (n == n_items / 2)
                drain();
            if (held_blocks.size() == 0 || $urandom_range(99) < alloc_pct)
            begin
                send_req(OP_ALLOC, BLK_W'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    bno = held_blocks[$urandom_range(held_blocks.size() - 1)];
                else if (pick < 82)
                    bno = BLK_W'($urandom);
                else if (pick < 87)
                    bno = '0;
                else
                    bno = BLK_W'(usable_blocks() + $urandom_range(15));
                send_req(OP_FREE, bno);
            end
        end
        drain();
    endtask

    // hand-picked requests around every status and count extreme
    task automatic test_directed_cases();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '1);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, BLK_W'(2));
        send_req(OP_FREE, BLK_W'(2));
        send_req(OP_FREE, '0);
        send_req(OP_FREE, '1);
        send_req(OP_FREE, BLK_W'(4000));
        send_req(OP_ALLOC, '0);
        // tiny count, full after three grants
        drain();
        write_count(CNT_W'(4));
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, BLK_W'(3));
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, BLK_W'(4));
        send_req(OP_FREE, BLK_W'(3));
        // count lowered under granted blocks
        drain();
        write_count(CNT_W'(2));
        send_req(OP_FREE, BLK_W'(2));
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, BLK_W'(1));
        send_req(OP_ALLOC, '0);
        // counts below two
        drain();
        write_count(CNT_W'(1));
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, BLK_W'(1));
        drain();
        write_count('0);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, '0);
        // count above capacity
        drain();
        write_count('1);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, BLK_W'(2048));
        drain();
    endtask

    task automatic test_fill_no_idle();
        run_mix(150, CNT_W'(16), 55, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_mix(150, CNT_W'(40), 60, 65, 0);
    endtask

    task automatic test_receiver_stalls();
        run_mix(150, CNT_W'(100), 75, 0, 65);
    endtask

    task automatic test_both_idle();
        run_mix(150, CNT_W'(8), 55, 12, 12);
    endtask

    task automatic test_full_count();
        run_mix(100, CNT_W'(NUM_BLOCKS), 60, 0, 65);
    endtask

    task automatic test_over_capacity();
        run_mix(100, '1, 50, 65, 0);
    endtask

    task automatic test_minimum_count();
        run_mix(50, CNT_W'(2), 50, 12, 12);
    endtask

    task automatic test_word_boundary();
        run_mix(50, CNT_W'(MAP_WORD_BITS + 1), 65, 0, 0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_full_count();
        test_over_capacity();
        test_minimum_count();
        test_word_boundary();
        drain();

        $display("covered %0d requests and %0d result beats over %0d count settings",
                 beats_sent, beats_checked, count_writes);
        $display("no-free answers %0d, not-in-use answers %0d, mismatches %0d",
                 no_free_seen, not_in_use_seen, mismatches);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
